### rtl/mlps_pkg.sv
// ----------------------------------------------------------------------------
// Monthly leaf phenology package
// Shared widths, codes, thresholds, record types and lookup functions for the
// monthly leaf phenology state block.
// ----------------------------------------------------------------------------
package mlps_pkg;

  // Calendar
  localparam int MONTHS = 12;

  // Field widths
  localparam int MONTH_W    = 4;
  localparam int TEMP_W     = 11;
  localparam int PRECIP_W   = 15;
  localparam int SOIL_W     = 16;
  localparam int AMT_W      = 10;
  localparam int CMT_W      = 11;
  localparam int GDD_W      = 18;
  localparam int GROW_W     = 9;
  localparam int DAYS_W     = 5;
  localparam int SEASON_W   = 2;
  localparam int VCODE_W    = 6;
  localparam int VKIND_W    = 2;
  localparam int CTEMP_W    = 10;
  localparam int FCAP_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Stream payload widths, padded to whole bytes
  localparam int IN_BITS   = MONTH_W + 1 + TEMP_W + PRECIP_W + SOIL_W + AMT_W + CMT_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = SEASON_W + GDD_W + GROW_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Saturation limits
  localparam logic [GDD_W-1:0]  GDD_MAX  = 18'h3FFFF;
  localparam logic [GROW_W-1:0] GROW_MAX = 9'h1FF;

  // Reset months
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
  localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd6;

  // Thresholds in 0.1 degree and 0.1 mm units
  localparam logic signed [TEMP_W-1:0] T_BASE       = 11'sd50;
  localparam logic signed [TEMP_W-1:0] T_C3_MIN     = 11'sd40;
  localparam logic signed [TEMP_W-1:0] T_C4_MIN     = 11'sd80;
  localparam logic signed [AMT_W-1:0]  AM_CROP_MIN  = 10'sd200;
  localparam logic signed [CMT_W-1:0]  MN_CROP_MIN  = 11'sd100;
  localparam logic [PRECIP_W-1:0]      PRECIP_MIN   = 15'd500;

  // Vegetation kind codes
  localparam logic [VKIND_W-1:0] VEG_KIND_NATURAL = 2'd1;
  localparam logic [VKIND_W-1:0] VEG_KIND_CROP    = 2'd2;

  // Season codes
  typedef enum logic [SEASON_W-1:0] {
    SEASON_DORMANT = 2'd0,
    SEASON_GROWING = 2'd1,
    SEASON_EMERGE  = 2'd2,
    SEASON_SHED    = 2'd3
  } season_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VEG_CODE   = 3'd0,
    CFG_VEG_KIND   = 3'd1,
    CFG_C4_GRASS   = 3'd2,
    CFG_TEMP_THR   = 3'd3,
    CFG_GDD_THR    = 3'd4,
    CFG_SOUTH      = 3'd5,
    CFG_FIELD_CAP  = 3'd6
  } cfg_idx_e;

  // Biome rule classes
  typedef enum logic [2:0] {
    BIOME_BARE       = 3'd0,
    BIOME_EVERGREEN  = 3'd1,
    BIOME_COLD_DECID = 3'd2,
    BIOME_ARID_DECID = 3'd3,
    BIOME_GRASS      = 3'd4,
    BIOME_CROP       = 3'd5,
    BIOME_NONE       = 3'd6
  } biome_e;

  // Configuration register set
  typedef struct packed {
    logic [VCODE_W-1:0]        veg_code;
    logic [VKIND_W-1:0]        veg_kind;
    logic                      c4_grass;
    logic signed [CTEMP_W-1:0] temp_thr;
    logic [GDD_W-1:0]          gdd_thr;
    logic                      south;
    logic [FCAP_W-1:0]         field_cap;
  } cfg_t;

  // One monthly climate record
  typedef struct packed {
    logic [MONTH_W-1:0]       month;
    logic                     first_year;
    logic signed [TEMP_W-1:0] month_temp;
    logic [PRECIP_W-1:0]      month_precip;
    logic [SOIL_W-1:0]        soil_water;
    logic signed [AMT_W-1:0]  annual_mean_temp;
    logic signed [CMT_W-1:0]  coldest_month_temp;
  } item_t;

  // Land cover class to biome rule
  function automatic biome_e biome_of(input logic [VCODE_W-1:0] code);
    biome_e b;
    unique case (code)
      6'd0, 6'd33:                                    b = BIOME_BARE;
      6'd1, 6'd2, 6'd6, 6'd7, 6'd8, 6'd9, 6'd11, 6'd13,
      6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26: b = BIOME_EVERGREEN;
      6'd4, 6'd5, 6'd10, 6'd12:                       b = BIOME_COLD_DECID;
      6'd3:                                           b = BIOME_ARID_DECID;
      6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19,
      6'd27, 6'd28:                                   b = BIOME_GRASS;
      6'd29, 6'd30, 6'd31, 6'd32:                     b = BIOME_CROP;
      default:                                        b = BIOME_NONE;
    endcase
    return b;
  endfunction

  // Non-leap month lengths; months past December count zero days
  function automatic logic [DAYS_W-1:0] days_of(input logic [MONTH_W-1:0] m);
    logic [DAYS_W-1:0] d;
    unique case (m)
      4'd0:    d = 5'd31;
      4'd1:    d = 5'd28;
      4'd2:    d = 5'd31;
      4'd3:    d = 5'd30;
      4'd4:    d = 5'd31;
      4'd5:    d = 5'd30;
      4'd6:    d = 5'd31;
      4'd7:    d = 5'd31;
      4'd8:    d = 5'd30;
      4'd9:    d = 5'd31;
      4'd10:   d = 5'd30;
      4'd11:   d = 5'd31;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

  // Degree-day reset month: January in the north, July in the south
  function automatic logic is_reset_month(input logic [MONTH_W-1:0] m, input logic south);
    return south ? (m == MONTH_JUL) : (m == MONTH_JAN);
  endfunction

endpackage

### rtl/monthly_leaf_phenology_state.sv
// A transferred record is held in the input register; its result enters the result
// register when the compute stage advances, which a low result ready can stall.
// Throughput: one record per cycle while results are taken; the running state updates in the single compute stage.
// While both registers are full, the input ready follows the result ready.
// Reset (rst_ni low, asynchronous) clears degree days, growing days and leaf flags,
// and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// Monthly leaf phenology state
// Accepts one monthly climate record per transfer and returns the season,
// degree days, growing days and a season-valid flag for the grid cell.
// ----------------------------------------------------------------------------
module monthly_leaf_phenology_state
  import mlps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Record stream in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // month[3:0], first_year[4], month_temp[15:5], month_precip[30:16],
  // soil_water[46:31], annual_mean_temp[56:47], coldest_month_temp[67:57]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Result stream out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // season[1:0], degree_days[19:2], growing_days[28:20], season_valid[29]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cfg_t                 cfg_q;
  item_t                item_q;
  logic                 in_vld_q;
  logic                 out_vld_q;
  logic [OUT_BITS-1:0]  out_q;
  logic                 adv;
  logic [GDD_W-1:0]     gdd;
  logic [GROW_W-1:0]    grow;
  season_e              season;
  logic                 season_valid;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.veg_code  <= '0;
      cfg_q.veg_kind  <= VEG_KIND_NATURAL;
      cfg_q.c4_grass  <= 1'b0;
      cfg_q.temp_thr  <= 10'sd50;
      cfg_q.gdd_thr   <= '0;
      cfg_q.south     <= 1'b0;
      cfg_q.field_cap <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VEG_CODE:  cfg_q.veg_code  <= cfg_wdata_i[VCODE_W-1:0];
        CFG_VEG_KIND:  cfg_q.veg_kind  <= cfg_wdata_i[VKIND_W-1:0];
        CFG_C4_GRASS:  cfg_q.c4_grass  <= cfg_wdata_i[0];
        CFG_TEMP_THR:  cfg_q.temp_thr  <= cfg_wdata_i[CTEMP_W-1:0];
        CFG_GDD_THR:   cfg_q.gdd_thr   <= cfg_wdata_i[GDD_W-1:0];
        CFG_SOUTH:     cfg_q.south     <= cfg_wdata_i[0];
        CFG_FIELD_CAP: cfg_q.field_cap <= cfg_wdata_i[FCAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the compute stage advances when its result can be stored
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.month              <= s_axis_tdata[3:0];
      item_q.first_year         <= s_axis_tdata[4];
      item_q.month_temp         <= s_axis_tdata[15:5];
      item_q.month_precip       <= s_axis_tdata[30:16];
      item_q.soil_water         <= s_axis_tdata[46:31];
      item_q.annual_mean_temp   <= s_axis_tdata[56:47];
      item_q.coldest_month_temp <= s_axis_tdata[67:57];
    end
  end

  // Running degree days and growing days
  mlps_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (adv),
    .south_i (cfg_q.south),
    .item_i  (item_q),
    .gdd_o   (gdd),
    .grow_o  (grow)
  );

  // Leaf flags and season classification
  mlps_season u_season (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (adv),
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .gdd_i    (gdd),
    .season_o (season),
    .valid_o  (season_valid)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {season_valid, grow, gdd, season};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, out_q};

endmodule

### rtl/mlps_accum.sv
// ----------------------------------------------------------------------------
// Degree-day and growing-day accumulator
// Holds the running degree days and growing days, clears them at their reset
// months and adds warm months with saturation.
// ----------------------------------------------------------------------------
module mlps_accum
  import mlps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              upd_i,
  input  logic              south_i,
  input  item_t             item_i,
  output logic [GDD_W-1:0]  gdd_o,
  output logic [GROW_W-1:0] grow_o
);

  logic [GDD_W-1:0]   gdd_q, gdd_d;
  logic [GROW_W-1:0]  grow_q, grow_d;
  logic [GDD_W-1:0]   gdd_base;
  logic [GROW_W-1:0]  grow_base;
  logic [DAYS_W-1:0]  days;
  logic               warm;
  logic [TEMP_W+DAYS_W-2:0] gdd_add;
  logic [GDD_W:0]     gdd_sum;
  logic [GROW_W:0]    grow_sum;

  // Clear at the reset months, then add the month when it is warm enough
  always_comb begin
    days      = days_of(item_i.month);
    gdd_base  = is_reset_month(item_i.month, south_i) ? '0 : gdd_q;
    grow_base = (item_i.month == MONTH_JAN) ? '0 : grow_q;
    warm      = item_i.month_temp > T_BASE;
    // A warm temperature is positive, so its low bits carry the magnitude
    gdd_add   = item_i.month_temp[TEMP_W-2:0] * days;
    gdd_sum   = {1'b0, gdd_base} + (GDD_W+1)'(gdd_add);
    grow_sum  = {1'b0, grow_base} + (GROW_W+1)'(days);
    gdd_d     = gdd_base;
    grow_d    = grow_base;
    if (warm) begin
      gdd_d  = (gdd_sum > {1'b0, GDD_MAX}) ? GDD_MAX : gdd_sum[GDD_W-1:0];
      grow_d = (grow_sum > {1'b0, GROW_MAX}) ? GROW_MAX : grow_sum[GROW_W-1:0];
    end
  end

  // State registers advance once per transferred record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gdd_q  <= '0;
      grow_q <= '0;
    end else if (upd_i) begin
      gdd_q  <= gdd_d;
      grow_q <= grow_d;
    end
  end

  assign gdd_o  = gdd_d;
  assign grow_o = grow_d;

endmodule

### rtl/mlps_season.sv
// ----------------------------------------------------------------------------
// Season classifier
// Holds the leaf-out and leaf-drop flags, seeds them in the first year and
// applies the biome rule to classify the month.
// ----------------------------------------------------------------------------
module mlps_season
  import mlps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             upd_i,
  input  cfg_t             cfg_i,
  input  item_t            item_i,
  input  logic [GDD_W-1:0] gdd_i,
  output season_e          season_o,
  output logic             valid_o
);

  logic                      out_q, out_d;
  logic                      drop_q, drop_d;
  logic                      out_seed, drop_seed;
  logic                      use_decid, dormant;
  logic                      dry, crop_hot, below_crit;
  logic [SOIL_W+3:0]         soil_x10;
  logic signed [TEMP_W-1:0]  crit_t;
  logic signed [TEMP_W-1:0]  grass_min;
  season_e                   season;
  logic                      valid;

  always_comb begin
    // First-year seeding at the degree-day reset month
    out_seed  = out_q;
    drop_seed = drop_q;
    if (is_reset_month(item_i.month, cfg_i.south) && item_i.first_year) begin
      out_seed  = cfg_i.south;
      drop_seed = !cfg_i.south;
    end

    // Shared tests
    soil_x10   = {1'b0, item_i.soil_water, 3'b000} + {3'b000, item_i.soil_water, 1'b0};
    dry        = soil_x10 < {4'b0000, cfg_i.field_cap};
    crit_t     = TEMP_W'(cfg_i.temp_thr);
    below_crit = item_i.month_temp < crit_t;
    crop_hot   = (item_i.annual_mean_temp > AM_CROP_MIN) &&
                 (item_i.coldest_month_temp > MN_CROP_MIN);
    grass_min  = cfg_i.c4_grass ? T_C4_MIN : T_C3_MIN;

    // Biome rule selection
    season    = SEASON_DORMANT;
    valid     = 1'b1;
    use_decid = 1'b0;
    dormant   = 1'b0;
    if (cfg_i.veg_kind == VEG_KIND_NATURAL) begin
      unique case (biome_of(cfg_i.veg_code))
        BIOME_BARE: begin
          season = SEASON_DORMANT;
        end
        BIOME_EVERGREEN: begin
          season = (item_i.month_temp >= T_BASE) ? SEASON_GROWING : SEASON_DORMANT;
        end
        BIOME_COLD_DECID: begin
          priority if (below_crit) begin
            use_decid = 1'b1;
            dormant   = 1'b1;
          end else if (gdd_i > cfg_i.gdd_thr) begin
            use_decid = 1'b1;
          end else begin
            season = SEASON_GROWING;
          end
        end
        BIOME_ARID_DECID: begin
          use_decid = 1'b1;
          dormant   = item_i.month_precip < PRECIP_MIN;
        end
        BIOME_GRASS: begin
          use_decid = 1'b1;
          dormant   = dry || (item_i.month_temp < grass_min);
        end
        BIOME_CROP: begin
          if (crop_hot) begin
            season = SEASON_GROWING;
          end else begin
            use_decid = 1'b1;
            dormant   = below_crit;
          end
        end
        default: begin
          valid = 1'b0;
        end
      endcase
    end else if (cfg_i.veg_kind == VEG_KIND_CROP) begin
      if (crop_hot) begin
        season = SEASON_GROWING;
      end else begin
        use_decid = 1'b1;
        dormant   = below_crit;
      end
    end else begin
      valid = 1'b0;
    end

    // Deciduous-style flag swap on shedding and emergence
    out_d  = out_seed;
    drop_d = drop_seed;
    if (use_decid) begin
      if (dormant) begin
        if (out_seed && !drop_seed) begin
          season = SEASON_SHED;
          out_d  = 1'b0;
          drop_d = 1'b1;
        end else begin
          season = SEASON_DORMANT;
        end
      end else if (!out_seed) begin
        season = SEASON_EMERGE;
        out_d  = 1'b1;
        drop_d = 1'b0;
      end else begin
        season = SEASON_GROWING;
      end
    end
  end

  // Flag registers advance once per transferred record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q  <= 1'b0;
      drop_q <= 1'b0;
    end else if (upd_i) begin
      out_q  <= out_d;
      drop_q <= drop_d;
    end
  end

  assign season_o = season;
  assign valid_o  = valid;

endmodule

### tb/phenology_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Monthly leaf phenology result checker
// Watches the configuration port and both record streams, predicts the season,
// degree days and growing days of every accepted record, and compares each
// result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module phenology_checker
  import mlps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port, observed only
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Record stream, observed only
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // month[3:0], first_year[4], month_temp[15:5], month_precip[30:16],
  // soil_water[46:31], annual_mean_temp[56:47], coldest_month_temp[67:57]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Result stream, observed only
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // season[1:0], degree_days[19:2], growing_days[28:20], season_valid[29]
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                    fail_count_o,
  output int                    outstanding_o
);

  // Thresholds in 0.1 degree and 0.1 mm units.
  localparam int GROW_BASE_TEMP  = 50;
  localparam int C3_MIN_TEMP     = 40;
  localparam int C4_MIN_TEMP     = 80;
  localparam int CROP_MEAN_MIN   = 200;
  localparam int CROP_COLD_MIN   = 100;
  localparam int ARID_PRECIP_MIN = 500;
  localparam int MOISTURE_SCALE  = 10;
  localparam int DEGREE_DAY_SAT  = 262143;
  localparam int GROW_DAY_SAT    = 511;

  typedef struct packed {
    season_e            season;
    logic [GDD_W-1:0]   degree_days;
    logic [GROW_W-1:0]  growing_days;
    logic               season_valid;
  } phen_result_t;

  // Shadow copy of the configuration registers.
  logic [VCODE_W-1:0]        cfg_veg_code  = '0;
  logic [VKIND_W-1:0]        cfg_veg_kind  = VEG_KIND_NATURAL;
  logic                      cfg_c4        = 1'b0;
  logic signed [CTEMP_W-1:0] cfg_temp_thr  = 10'sd50;
  logic [GDD_W-1:0]          cfg_gdd_thr   = '0;
  logic                      cfg_south     = 1'b0;
  logic [FCAP_W-1:0]         cfg_field_cap = 16'd1000;

  // Running cell state.
  int   gdd_acc      = 0;
  int   grow_acc     = 0;
  bit   leaf_out     = 1'b0;
  bit   leaf_dropped = 1'b0;

  phen_result_t expected_results[$];
  int           failures = 0;

  phen_result_t                  want;
  logic                          got_valid;
  logic [GROW_W-1:0]             got_grow;
  logic [GDD_W-1:0]              got_gdd;
  logic [SEASON_W-1:0]           got_season;

  assign fail_count_o = failures;

  function automatic int month_length(input logic [MONTH_W-1:0] m);
    case (m)
      4'd1:                      return 28;
      4'd3, 4'd5, 4'd8, 4'd10:   return 30;
      4'd0, 4'd2, 4'd4, 4'd6,
      4'd7, 4'd9, 4'd11:         return 31;
      default:                   return 0;
    endcase
  endfunction

  // Land cover class to biome rule.
  function automatic biome_e biome_class(input logic [VCODE_W-1:0] code);
    case (code)
      0, 33:                                       return BIOME_BARE;
      1, 2, 6, 7, 8, 9, 11, 13, 20, 21, 22, 23,
      24, 25, 26:                                  return BIOME_EVERGREEN;
      4, 5, 10, 12:                                return BIOME_COLD_DECID;
      3:                                           return BIOME_ARID_DECID;
      14, 15, 16, 17, 18, 19, 27, 28:              return BIOME_GRASS;
      29, 30, 31, 32:                              return BIOME_CROP;
      default:                                     return BIOME_NONE;
    endcase
  endfunction

  // Leaves come out on the first active month and drop on the first dormant one.
  function automatic season_e leaf_transition(input bit dormant);
    if (dormant) begin
      if (leaf_out && !leaf_dropped) begin
        leaf_dropped = 1'b1;
        leaf_out     = 1'b0;
        return SEASON_SHED;
      end
      return SEASON_DORMANT;
    end
    if (!leaf_out) begin
      leaf_out     = 1'b1;
      leaf_dropped = 1'b0;
      return SEASON_EMERGE;
    end
    return SEASON_GROWING;
  endfunction

  // Warm cropland grows all year; elsewhere the critical temperature decides.
  function automatic season_e crop_season(input int temp, input int am, input int mn,
                                          input int crit);
    if (am > CROP_MEAN_MIN && mn > CROP_COLD_MIN) return SEASON_GROWING;
    return leaf_transition(temp < crit);
  endfunction

  // Advances the cell state by one monthly record and returns its result.
  function automatic phen_result_t predict_month(input logic [IN_DATA_W-1:0] rec);
    logic [MONTH_W-1:0]           month;
    logic                         first;
    logic signed [TEMP_W-1:0]     t;
    logic [PRECIP_W-1:0]          precip;
    logic [SOIL_W-1:0]            soil;
    logic signed [AMT_W-1:0]      am;
    logic signed [CMT_W-1:0]      mn;
    int                           temp, crit, days, sum;
    bit                           dry, reset_month;
    season_e                      season;
    phen_result_t                 r;
    {mn, am, soil, precip, t, first, month} = rec[IN_BITS-1:0];
    temp = t;
    crit = cfg_temp_thr;
    days = month_length(month);

    // Degree days restart in January or July; the first year seeds the flags.
    reset_month = cfg_south ? (month == MONTH_JUL) : (month == MONTH_JAN);
    if (reset_month) begin
      gdd_acc = 0;
      if (first) begin
        leaf_dropped = !cfg_south;
        leaf_out     = cfg_south;
      end
    end
    if (month == MONTH_JAN) grow_acc = 0;
    if (temp > GROW_BASE_TEMP) begin
      sum      = gdd_acc + temp * days;
      gdd_acc  = (sum > DEGREE_DAY_SAT) ? DEGREE_DAY_SAT : sum;
      sum      = grow_acc + days;
      grow_acc = (sum > GROW_DAY_SAT) ? GROW_DAY_SAT : sum;
    end

    // Season classification by the selected biome rule.
    season         = SEASON_DORMANT;
    r.season_valid = 1'b1;
    dry            = int'(soil) * MOISTURE_SCALE < int'(cfg_field_cap);
    if (cfg_veg_kind == VEG_KIND_NATURAL) begin
      case (biome_class(cfg_veg_code))
        BIOME_BARE:       season = SEASON_DORMANT;
        BIOME_EVERGREEN: begin
          if (temp >= GROW_BASE_TEMP) season = SEASON_GROWING;
        end
        BIOME_COLD_DECID: begin
          if (temp < crit) season = leaf_transition(1'b1);
          else if (gdd_acc > int'(cfg_gdd_thr)) season = leaf_transition(1'b0);
          else season = SEASON_GROWING;
        end
        BIOME_ARID_DECID: season = leaf_transition(int'(precip) < ARID_PRECIP_MIN);
        BIOME_GRASS:      season = leaf_transition(dry ||
                                   temp < (cfg_c4 ? C4_MIN_TEMP : C3_MIN_TEMP));
        BIOME_CROP:       season = crop_season(temp, am, mn, crit);
        default:          r.season_valid = 1'b0;
      endcase
    end else if (cfg_veg_kind == VEG_KIND_CROP) begin
      season = crop_season(temp, am, mn, crit);
    end else begin
      r.season_valid = 1'b0;
    end

    r.season       = season;
    r.degree_days  = gdd_acc[GDD_W-1:0];
    r.growing_days = grow_acc[GROW_W-1:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      failures++;
    end
  endfunction

  // Track configuration writes, predict on each record transfer and check results.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_veg_code  = '0;
      cfg_veg_kind  = VEG_KIND_NATURAL;
      cfg_c4        = 1'b0;
      cfg_temp_thr  = 10'sd50;
      cfg_gdd_thr   = '0;
      cfg_south     = 1'b0;
      cfg_field_cap = 16'd1000;
      gdd_acc       = 0;
      grow_acc      = 0;
      leaf_out      = 1'b0;
      leaf_dropped  = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_VEG_CODE:  cfg_veg_code  = cfg_wdata_i[VCODE_W-1:0];
          CFG_VEG_KIND:  cfg_veg_kind  = cfg_wdata_i[VKIND_W-1:0];
          CFG_C4_GRASS:  cfg_c4        = cfg_wdata_i[0];
          CFG_TEMP_THR:  cfg_temp_thr  = cfg_wdata_i[CTEMP_W-1:0];
          CFG_GDD_THR:   cfg_gdd_thr   = cfg_wdata_i[GDD_W-1:0];
          CFG_SOUTH:     cfg_south     = cfg_wdata_i[0];
          CFG_FIELD_CAP: cfg_field_cap = cfg_wdata_i[FCAP_W-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_month(s_axis_tdata));

      if (m_axis_tvalid && m_axis_tready) begin
        {got_valid, got_grow, got_gdd, got_season} = m_axis_tdata[OUT_BITS-1:0];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, season %0d gdd %0d grow %0d valid %0d",
                   $time, got_season, got_gdd, got_grow, got_valid);
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("season", want.season, got_season);
          check_field("degree_days", want.degree_days, got_gdd);
          check_field("growing_days", want.growing_days, got_grow);
          check_field("season_valid", want.season_valid, got_valid);
        end
      end
    end
    outstanding_o = expected_results.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Monthly leaf phenology testbench
// Drives directed records that hit every biome rule and corner case, then
// phases of seasonal climate years with random content under changing
// register settings, with random idling on both streams and a long result stall.
// ----------------------------------------------------------------------------
module testbench
  import mlps_pkg::*;
();

  localparam int IDLE_PCT      = 12;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 2000;

  // Representative land cover classes.
  localparam int LC_BARE      = 0;
  localparam int LC_EVERGREEN = 1;
  localparam int LC_ARID      = 3;
  localparam int LC_COLD      = 4;
  localparam int LC_COLD_ALT  = 5;
  localparam int LC_GRASS     = 14;
  localparam int LC_CROP      = 29;
  localparam int LC_BARE_ALT  = 33;
  localparam int LC_UNLISTED  = 63;

  // Vegetation kinds that disable the season update.
  localparam logic [VKIND_W-1:0] VEG_KIND_OFF_LO = 2'd0;
  localparam logic [VKIND_W-1:0] VEG_KIND_OFF_HI = 2'd3;

  localparam int TEMP_THR_MIN  = -512;
  localparam int TEMP_THR_MAX  = 511;
  localparam int GDD_THR_MAX   = 262143;
  localparam int FIELD_CAP_MAX = 65535;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int pending_results;
  int failure_total;
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;

  monthly_leaf_phenology_state dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  phenology_checker u_phenology_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (failure_total),
    .outstanding_o (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result sink: random backpressure, plus one long hold-off on request.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: ends the run after a long stretch without any transfer.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stalled = 0;
      else
        stalled++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [IN_DATA_W-1:0] pack_record(input int month, input int first,
                                                       input int t, input int precip,
                                                       input int soil, input int am,
                                                       input int mn);
    return {{(IN_DATA_W-IN_BITS){1'b0}}, mn[CMT_W-1:0], am[AMT_W-1:0], soil[SOIL_W-1:0],
            precip[PRECIP_W-1:0], t[TEMP_W-1:0], first[0], month[MONTH_W-1:0]};
  endfunction

  // Temperature offset of each month in tenths of the annual amplitude.
  function automatic int season_shape(input int m);
    case (m)
      0:       return -10;
      1, 11:   return -8;
      2, 10:   return -4;
      3, 9:    return 1;
      4:       return 5;
      5, 7:    return 9;
      6:       return 10;
      8:       return 6;
      default: return 0;
    endcase
  endfunction

  function automatic int pick_code(input biome_e rule);
    case (rule)
      BIOME_EVERGREEN: begin
        case ($urandom_range(3))
          0:       return LC_EVERGREEN;
          1:       return 8;
          2:       return 13;
          default: return 24;
        endcase
      end
      BIOME_COLD_DECID: begin
        case ($urandom_range(3))
          0:       return LC_COLD;
          1:       return LC_COLD_ALT;
          2:       return 10;
          default: return 12;
        endcase
      end
      BIOME_ARID_DECID: return LC_ARID;
      BIOME_GRASS: begin
        case ($urandom_range(3))
          0:       return LC_GRASS;
          1:       return 18;
          2:       return 27;
          default: return 28;
        endcase
      end
      BIOME_CROP: return LC_CROP + $urandom_range(3);
      default:    return $urandom_range(34, LC_UNLISTED);
    endcase
  endfunction

  // One record transfer, with random idle cycles ahead of it.
  task automatic send_record(input logic [IN_DATA_W-1:0] rec);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rec;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_month(input int month, input int first, input int t, input int precip,
                            input int soil, input int am, input int mn);
    send_record(pack_record(month, first, t, precip, soil, am, mn));
  endtask

  // Stop offering records and wait until every result has come back.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input int value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
  endtask

  // Loads a full register setting while the block is idle.
  task automatic set_rule(input int code, input int kind, input int c4, input int crit,
                          input int gdd_limit, input int south, input int fcap);
    quiesce();
    write_cfg(CFG_VEG_CODE, code);
    write_cfg(CFG_VEG_KIND, kind);
    write_cfg(CFG_C4_GRASS, c4);
    write_cfg(CFG_TEMP_THR, crit & ((1 << CTEMP_W) - 1));
    write_cfg(CFG_GDD_THR, gdd_limit);
    write_cfg(CFG_SOUTH, south);
    write_cfg(CFG_FIELD_CAP, fcap);
    cfg_we_i <= 1'b0;
  endtask

  // Directed records: field extremes, every biome rule and the corner cases.
  task automatic run_directed();
    // Evergreen: coldest and hottest records, the growth threshold, bad months.
    set_rule(LC_EVERGREEN, VEG_KIND_NATURAL, 0, 50, 0, 0, 1000);
    send_month(0, 1, -1024, 0, 0, -512, -1024);
    send_month(1, 0, 50, 100, 100, 0, 0);
    send_month(2, 0, 51, 100, 100, 0, 0);
    send_month(12, 0, 1023, 100, 100, 0, 0);
    send_month(15, 1, 1023, 32767, 65535, 511, 1023);
    // Cold deciduous in the south: July seeding, then shedding and emergence.
    set_rule(LC_COLD, VEG_KIND_NATURAL, 0, TEMP_THR_MIN, 0, 1, 1000);
    send_month(6, 1, -600, 300, 300, 0, -300);
    send_month(7, 0, 200, 300, 300, 0, -300);
    send_month(8, 0, 200, 300, 300, 0, -300);
    // Arid deciduous around the precipitation threshold.
    set_rule(LC_ARID, VEG_KIND_NATURAL, 0, 50, 0, 0, 1000);
    send_month(0, 1, 250, 499, 300, 250, 150);
    send_month(1, 0, 250, 500, 300, 250, 150);
    send_month(2, 0, 250, 499, 300, 250, 150);
    // C4 grass with zero field capacity, then C3 grass at the dry threshold.
    set_rule(LC_GRASS, VEG_KIND_NATURAL, 1, 50, 0, 0, 0);
    send_month(3, 0, 79, 300, 0, 100, 0);
    send_month(4, 0, 80, 300, 0, 100, 0);
    set_rule(LC_GRASS, VEG_KIND_NATURAL, 0, 50, 0, 0, FIELD_CAP_MAX);
    send_month(5, 0, 40, 300, 6553, 100, 0);
    send_month(6, 0, 40, 300, 6554, 100, 0);
    // Natural cropland: warm shortcut and the critical temperature rule.
    set_rule(LC_CROP, VEG_KIND_NATURAL, 0, TEMP_THR_MAX, 0, 0, 1000);
    send_month(7, 0, 300, 300, 300, 201, 101);
    send_month(8, 0, 0, 300, 300, 200, 101);
    // Forced cropland ignores the land cover class.
    set_rule(LC_BARE, VEG_KIND_CROP, 0, TEMP_THR_MAX, 0, 0, 1000);
    send_month(9, 0, 511, 300, 300, 201, 100);
    // Cold deciduous held back by an unreachable degree-day threshold.
    set_rule(LC_COLD_ALT, VEG_KIND_NATURAL, 0, 0, GDD_THR_MAX, 0, 1000);
    send_month(5, 0, 100, 300, 300, 100, 0);
    // No season update, and bare ground.
    set_rule(LC_EVERGREEN, VEG_KIND_OFF_LO, 0, 50, 0, 0, 1000);
    send_month(6, 0, 300, 300, 300, 100, 0);
    set_rule(LC_EVERGREEN, VEG_KIND_OFF_HI, 0, 50, 0, 0, 1000);
    send_month(7, 0, 300, 300, 300, 100, 0);
    set_rule(LC_UNLISTED, VEG_KIND_NATURAL, 0, 50, 0, 0, 1000);
    send_month(8, 0, 300, 300, 300, 100, 0);
    set_rule(LC_BARE_ALT, VEG_KIND_NATURAL, 0, 50, 0, 0, 1000);
    send_month(9, 0, 300, 300, 300, 100, 0);
  endtask

  // A phase of seasonal climate years under one register setting, with noise
  // records and occasional jumps in the month order.
  task automatic run_phase(input int p, input int n_items);
    biome_e rule;
    int     code, kind, crit, gdd_limit, fcap, mean, amp, m, k, t, am, mn, soil;
    bit     south, first, skip_resets, hot;
    case (p)
      0:         rule = BIOME_EVERGREEN;
      1, 6, 9:   rule = BIOME_COLD_DECID;
      2, 10:     rule = BIOME_ARID_DECID;
      3, 7:      rule = BIOME_GRASS;
      8:         rule = BIOME_NONE;
      default:   rule = BIOME_CROP;
    endcase
    code = pick_code(rule);
    kind = VEG_KIND_NATURAL;
    if (p == 5) begin
      kind = VEG_KIND_CROP;
      code = $urandom_range(LC_UNLISTED);
    end
    if (p == 8 && $urandom_range(1))
      kind = $urandom_range(1) ? VEG_KIND_OFF_LO : VEG_KIND_OFF_HI;

    if (p == 1) crit = TEMP_THR_MIN;
    else if (p == 6) crit = TEMP_THR_MAX;
    else crit = int'($urandom_range(400)) - 200;
    if (p == 1) gdd_limit = 0;
    else if (p == 6) gdd_limit = GDD_THR_MAX;
    else if (p == 9) gdd_limit = $urandom_range(GDD_THR_MAX);
    else gdd_limit = $urandom_range(30000);
    if (p == 3) fcap = 0;
    else if (p == 7) fcap = FIELD_CAP_MAX;
    else fcap = $urandom_range(1, 4000);
    south = $urandom_range(1);

    set_rule(code, kind, p % 2, crit, gdd_limit, south, fcap);

    // Phase 9 skips the reset months in its climate records, so both sums run into saturation.
    skip_resets = (p == 9);
    hot         = (p == 9);
    quiet       = (p == 2);
    if (p == 4) hold_req = 1'b1;
    mean  = int'($urandom_range(300)) - 100;
    amp   = $urandom_range(30, 250);
    first = (p == 0) || ($urandom_range(2) == 0);
    m     = (p == 0) ? 0 : $urandom_range(MONTHS - 1);

    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(99) < 10) begin
        send_record(pack_record($urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom));
      end else begin
        while (skip_resets && (m == MONTH_JAN || m == MONTH_JUL)) m = (m + 1) % MONTHS;
        if (hot)
          t = $urandom_range(800, 1023);
        else
          t = mean + amp * (south ? -season_shape(m) : season_shape(m)) / 10
              + int'($urandom_range(40)) - 20;
        if ($urandom_range(99) < 30) begin
          am = $urandom_range(180, 400);
          mn = $urandom_range(80, 400);
        end else begin
          am = mean;
          mn = mean - amp;
        end
        soil = $urandom_range(1) ? $urandom_range(400) : $urandom_range(65535);
        send_month(m, first, t, $urandom_range(1000), soil, am, mn);
        if (m == MONTHS - 1) first = 1'b0;
        m = ($urandom_range(99) < 6) ? $urandom_range(MONTHS - 1) : (m + 1) % MONTHS;
      end
    end
    quiet = 1'b0;
  endtask

  // Main stimulus and verdict.
  initial begin : stimulus
    int p;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_VEG_CODE;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    for (p = 0; p < 12; p++) run_phase(p, (p == 8) ? 20 : 46);

    quiesce();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failure_total == 0 && pending_results == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
